>>> hw/rtl/wfts_pkg.sv
// Shared types, constants and the nice-to-weight table of the task scheduler.
`timescale 1ns / 1ps
package wfts_pkg;

  localparam int SLOTS = 64;
  localparam int SW = 6;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_EMBRYO   = 3'd1;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;
  localparam logic [2:0] ST_ZOMBIE   = 3'd5;

  localparam logic [3:0] F_CREATE  = 4'd0;
  localparam logic [3:0] F_SETNICE = 4'd1;
  localparam logic [3:0] F_GETNICE = 4'd2;
  localparam logic [3:0] F_SLEEP   = 4'd3;
  localparam logic [3:0] F_WAKEUP  = 4'd4;
  localparam logic [3:0] F_PICK    = 4'd5;
  localparam logic [3:0] F_YIELD   = 4'd6;
  localparam logic [3:0] F_EXIT    = 4'd7;
  localparam logic [3:0] F_FREE    = 4'd8;
  localparam logic [3:0] F_KILL    = 4'd9;

  localparam logic [1:0] S_OK   = 2'd0;
  localparam logic [1:0] S_NF   = 2'd1;
  localparam logic [1:0] S_NICE = 2'd2;
  localparam logic [1:0] S_FULL = 2'd3;

  localparam logic [20:0] WAKE_CREDIT = 21'd1024000;

  // One table slot as held in the memory.
  typedef struct packed {
    logic [2:0]  st;
    logic [15:0] pid;
    logic [5:0]  nice;
    logic [16:0] weight;
    logic [31:0] vrt;
    logic [31:0] chan;
    logic        killed;
  } slot_t;

  typedef enum logic [3:0] {
    P_IDLE, P_CLEAR, P_SCAN, P_EXEC, P_DIV, P_WAKE, P_FIN, P_DONE
  } phase_t;

  // Divider request between the sequencer and the divide unit.
  typedef struct packed {
    logic        go;
    logic [36:0] num;
    logic [22:0] den;
  } div_req_t;

  function automatic logic [16:0] weight_of(input logic [5:0] n);
    logic [16:0] w;
    case (n)
      6'd0: w = 17'd88761;  6'd1: w = 17'd71755;  6'd2: w = 17'd56483;
      6'd3: w = 17'd46273;  6'd4: w = 17'd36291;  6'd5: w = 17'd29154;
      6'd6: w = 17'd23254;  6'd7: w = 17'd18705;  6'd8: w = 17'd14949;
      6'd9: w = 17'd11916;  6'd10: w = 17'd9548;  6'd11: w = 17'd7620;
      6'd12: w = 17'd6100;  6'd13: w = 17'd4904;  6'd14: w = 17'd3906;
      6'd15: w = 17'd3121;  6'd16: w = 17'd2501;  6'd17: w = 17'd1991;
      6'd18: w = 17'd1586;  6'd19: w = 17'd1277;  6'd20: w = 17'd1024;
      6'd21: w = 17'd820;   6'd22: w = 17'd655;   6'd23: w = 17'd526;
      6'd24: w = 17'd423;   6'd25: w = 17'd335;   6'd26: w = 17'd272;
      6'd27: w = 17'd215;   6'd28: w = 17'd172;   6'd29: w = 17'd137;
      6'd30: w = 17'd110;   6'd31: w = 17'd87;    6'd32: w = 17'd70;
      6'd33: w = 17'd56;    6'd34: w = 17'd45;    6'd35: w = 17'd36;
      6'd36: w = 17'd29;    6'd37: w = 17'd23;    6'd38: w = 17'd18;
      6'd39: w = 17'd15;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/wfts_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wfts_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wfts_pkg::div_req_t req,
  output logic              done,
  output logic [36:0]       quo
);
  logic [36:0] q_r, q_nxt;
  logic [22:0] d_r, d_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [23:0] sh;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r[22:0], q_r[36]};
    if (req.go) begin
      q_nxt = req.num; d_nxt = req.den; rem_nxt = '0;
      cnt_nxt = 6'd36; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[35:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[35:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

>>> hw/rtl/weighted_fair_task_scheduler.sv
// Top level of the weighted fair task scheduler: slot memory and op sequencer.
`timescale 1ns / 1ps
// The block holds a 64-slot task table in one synchronous memory.
// An op is taken when start is high and busy is low; its fields are in_*.
// Every op gives exactly one result, shown on out_* for one cycle with
// out_valid high; the receiver cannot stall and must take it then.
// Each op first scans all slots through the memory read port (one slot a
// cycle), gathering the first unused slot, the pid match, the minimum
// runnable vruntime and the total runnable weight. A single-slot op then
// reads and updates its target slot. Pick then also runs a division on the
// shared divider; wakeup runs a second pass over all slots, with a division
// for each woken slot when something is runnable. Busy drops in the cycle
// after the result beat.
// After reset the block runs a clearing pass over all slots with busy high;
// slice_budget resets to 10000 and the next pid to 1. Configuration writes
// on the APB port are taken at any time; slice_budget is at 0x0.
module weighted_fair_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_func,
  input  logic [15:0] in_process_id,
  input  logic [5:0]  in_slot_index,
  input  logic signed [6:0]  in_nice_value,
  input  logic [31:0] in_wait_channel,
  input  logic signed [31:0] in_vruntime_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_chosen_slot,
  output logic [15:0] out_chosen_pid,
  output logic [5:0]  out_nice_out,
  output logic [15:0] out_time_slice,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int SW = wfts_pkg::SW;

  wfts_pkg::slot_t mem [wfts_pkg::SLOTS];
  wfts_pkg::slot_t rd_r;
  logic [SW-1:0]   ra;
  logic            we;
  logic [SW-1:0]   wa;
  wfts_pkg::slot_t wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  logic [15:0] budget_r;
  assign pready = 1'b1;
  assign prdata = paddr == 1'b0 ? {16'd0, budget_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) budget_r <= 16'd10000;
    else if (psel && penable && pwrite && paddr == 1'b0) budget_r <= pwdata[15:0];
  end

  wfts_pkg::phase_t ph_r, ph_nxt;
  logic [SW:0] cnt_r, cnt_nxt;
  logic [3:0]  f_r;
  logic [15:0] pidq_r, npid_r, npid_nxt;
  logic [5:0]  sl_r;
  logic signed [6:0] nice_r;
  logic [31:0] ch_r, vin_r;
  logic        fu_v_r, fu_v_nxt, pm_v_r, pm_v_nxt, any_r, any_nxt;
  logic [SW-1:0] fu_r, fu_nxt, pm_r, pm_nxt, mi_r, mi_nxt;
  logic signed [31:0] minv_r, minv_nxt;
  logic [22:0] tot_r, tot_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [5:0]  os_r, os_nxt, on_r, on_nxt;
  logic [15:0] op_r, op_nxt, ot_r, ot_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  sub_r, sub_nxt;
  wfts_pkg::div_req_t dreq;
  logic        ddone;
  logic [36:0] dquo;
  logic [16:0] wsel;
  logic [32:0] vtmp;
  logic [32:0] prod;
  logic [16:0] wt_r;
  logic        acc;
  logic        div_started_r;

  wfts_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quo(dquo));

  assign acc = start && !busy;
  assign busy = ph_r != wfts_pkg::P_IDLE;
  logic nice_ok, slot_ok;
  assign nice_ok = !nice_r[6] && nice_r[5:0] <= 6'd39;
  assign slot_ok = 1'b1;
  assign wsel = rd_r.weight == 17'd0 ? 17'd1 : rd_r.weight;
  assign prod = 33'(budget_r) * 33'(wt_r);

  // Next state.
  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      wfts_pkg::P_IDLE:  if (acc) ph_nxt = wfts_pkg::P_SCAN;
      wfts_pkg::P_CLEAR: if (cnt_r == (SW+1)'(wfts_pkg::SLOTS - 1)) ph_nxt = wfts_pkg::P_IDLE;
      wfts_pkg::P_SCAN:  if (cnt_r == (SW+1)'(wfts_pkg::SLOTS)) ph_nxt = wfts_pkg::P_EXEC;
      wfts_pkg::P_EXEC: begin
        if (sub_r == 2'd2) begin
          if (f_r == wfts_pkg::F_PICK && any_r) ph_nxt = wfts_pkg::P_DIV;
          else if (f_r == wfts_pkg::F_WAKEUP) ph_nxt = wfts_pkg::P_WAKE;
          else ph_nxt = wfts_pkg::P_FIN;
        end
      end
      wfts_pkg::P_DIV:   if (ddone) ph_nxt = wfts_pkg::P_FIN;
      wfts_pkg::P_WAKE:  if (cnt_r == (SW+1)'(wfts_pkg::SLOTS)) ph_nxt = wfts_pkg::P_FIN;
      wfts_pkg::P_FIN:   ph_nxt = wfts_pkg::P_DONE;
      wfts_pkg::P_DONE:  ph_nxt = wfts_pkg::P_IDLE;
      default:           ph_nxt = wfts_pkg::P_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_nxt = cnt_r; npid_nxt = npid_r;
    fu_v_nxt = fu_v_r; fu_nxt = fu_r; pm_v_nxt = pm_v_r; pm_nxt = pm_r;
    any_nxt = any_r; mi_nxt = mi_r; minv_nxt = minv_r; tot_nxt = tot_r;
    st_nxt = st_r; os_nxt = os_r; on_nxt = on_r;
    op_nxt = op_r; ot_nxt = ot_r; sub_nxt = sub_r;
    ra = cnt_r[SW-1:0]; we = 1'b0; wa = cnt_r[SW-1:0]; wd = rd_r;
    dreq = '0; vtmp = '0;
    case (ph_r)
      wfts_pkg::P_IDLE: begin
        cnt_nxt = '0; ra = '0;
        fu_v_nxt = 1'b0; pm_v_nxt = 1'b0; any_nxt = 1'b0;
        tot_nxt = '0; minv_nxt = 32'sh7fffffff; mi_nxt = '0;
        st_nxt = wfts_pkg::S_NF; os_nxt = '0; on_nxt = '0; op_nxt = '0; ot_nxt = '0;
        sub_nxt = '0;
      end
      wfts_pkg::P_CLEAR: begin
        we = 1'b1; wa = cnt_r[SW-1:0]; wd = '0;
        cnt_nxt = cnt_r + 1'b1;
      end
      wfts_pkg::P_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        // rd_r holds slot cnt_r-1 once cnt_r is at least one.
        if (cnt_r != '0) begin
          if (rd_r.st == wfts_pkg::ST_UNUSED && !fu_v_r) begin
            fu_v_nxt = 1'b1; fu_nxt = SW'(cnt_r - 1'b1);
          end
          if (rd_r.st != wfts_pkg::ST_UNUSED && rd_r.pid == pidq_r && !pm_v_r) begin
            pm_v_nxt = 1'b1; pm_nxt = SW'(cnt_r - 1'b1);
          end
          if (rd_r.st == wfts_pkg::ST_RUNNABLE) begin
            any_nxt = 1'b1;
            tot_nxt = tot_r + 23'(rd_r.weight);
            if (!any_r || $signed(rd_r.vrt) < minv_r) begin
              minv_nxt = $signed(rd_r.vrt); mi_nxt = SW'(cnt_r - 1'b1);
            end
          end
        end
      end
      wfts_pkg::P_EXEC: begin
        // Step 0 addresses the target slot, step 1 waits, step 2 writes.
        sub_nxt = sub_r + 2'd1;
        case (f_r)
          wfts_pkg::F_SETNICE, wfts_pkg::F_GETNICE, wfts_pkg::F_KILL: ra = pm_r;
          wfts_pkg::F_PICK: ra = mi_r;
          wfts_pkg::F_CREATE: ra = fu_r;
          default: ra = sl_r;
        endcase
        wa = ra;
        if (sub_r == 2'd2) begin
          cnt_nxt = '0; ra = '0; sub_nxt = 2'd0;
          case (f_r)
            wfts_pkg::F_CREATE: begin
              if (!nice_ok) st_nxt = wfts_pkg::S_NICE;
              else if (!fu_v_r) st_nxt = wfts_pkg::S_FULL;
              else begin
                we = 1'b1;
                wd = '{st: wfts_pkg::ST_RUNNABLE, pid: npid_r, nice: nice_r[5:0],
                       weight: wfts_pkg::weight_of(nice_r[5:0]), vrt: vin_r,
                       chan: 32'd0, killed: 1'b0};
                st_nxt = wfts_pkg::S_OK; os_nxt = fu_r; op_nxt = npid_r;
                npid_nxt = npid_r + 16'd1;
              end
            end
            wfts_pkg::F_SETNICE: begin
              if (!nice_ok) st_nxt = wfts_pkg::S_NICE;
              else if (pm_v_r) begin
                we = 1'b1; wd.nice = nice_r[5:0];
                wd.weight = wfts_pkg::weight_of(nice_r[5:0]);
                st_nxt = wfts_pkg::S_OK;
              end
            end
            wfts_pkg::F_GETNICE: if (pm_v_r) begin
              on_nxt = rd_r.nice; st_nxt = wfts_pkg::S_OK;
            end
            wfts_pkg::F_KILL: if (pm_v_r) begin
              we = 1'b1; wd.killed = 1'b1;
              if (rd_r.st == wfts_pkg::ST_SLEEPING) wd.st = wfts_pkg::ST_RUNNABLE;
              st_nxt = wfts_pkg::S_OK;
            end
            wfts_pkg::F_SLEEP: if (slot_ok && (rd_r.st == wfts_pkg::ST_RUNNABLE ||
                                               rd_r.st == wfts_pkg::ST_RUNNING)) begin
              we = 1'b1; wd.chan = ch_r; wd.st = wfts_pkg::ST_SLEEPING;
              st_nxt = wfts_pkg::S_OK;
            end
            wfts_pkg::F_YIELD: if (rd_r.st == wfts_pkg::ST_RUNNING) begin
              we = 1'b1; wd.st = wfts_pkg::ST_RUNNABLE; wd.vrt = vin_r;
              st_nxt = wfts_pkg::S_OK;
            end
            wfts_pkg::F_EXIT: if (rd_r.st >= wfts_pkg::ST_EMBRYO &&
                                  rd_r.st <= wfts_pkg::ST_RUNNING) begin
              we = 1'b1; wd.st = wfts_pkg::ST_ZOMBIE; st_nxt = wfts_pkg::S_OK;
            end
            wfts_pkg::F_FREE: if (rd_r.st == wfts_pkg::ST_ZOMBIE) begin
              we = 1'b1; wd = '0; st_nxt = wfts_pkg::S_OK;
            end
            wfts_pkg::F_PICK: if (any_r) begin
              we = 1'b1; wd.st = wfts_pkg::ST_RUNNING;
              os_nxt = mi_r; op_nxt = rd_r.pid;
            end
            wfts_pkg::F_WAKEUP: st_nxt = wfts_pkg::S_OK;
            default: ;
          endcase
        end
      end
      wfts_pkg::P_DIV: begin
        // wt_r was latched from the picked slot; the product feeds the divider.
        if (sub_r == 2'd3) begin
          dreq.go = 1'b1; dreq.num = 37'(prod);
          dreq.den = tot_r == '0 ? 23'd1 : tot_r;
          sub_nxt = 2'd0;
        end
        if (ddone) begin
          ot_nxt = dquo[15:0]; st_nxt = wfts_pkg::S_OK;
        end
      end
      wfts_pkg::P_WAKE: begin
        // sub 0: address, 1: data, 2: decide, 3: wait on divide.
        ra = cnt_r[SW-1:0]; wa = cnt_r[SW-1:0];
        case (sub_r)
          2'd0: sub_nxt = 2'd1;
          2'd1: sub_nxt = 2'd2;
          2'd2: begin
            if (rd_r.st == wfts_pkg::ST_SLEEPING && rd_r.chan == ch_r) begin
              if (any_r) begin
                dreq.go = 1'b1; dreq.num = 37'(wfts_pkg::WAKE_CREDIT);
                dreq.den = 23'(wsel); sub_nxt = 2'd3;
              end else begin
                we = 1'b1; wd.st = wfts_pkg::ST_RUNNABLE; wd.vrt = '0;
                sub_nxt = 2'd0; cnt_nxt = cnt_r + 1'b1;
              end
            end else begin
              sub_nxt = 2'd0; cnt_nxt = cnt_r + 1'b1;
            end
          end
          default: if (ddone) begin
            vtmp = {minv_r[31], minv_r} - {12'd0, dquo[20:0]};
            we = 1'b1; wd.st = wfts_pkg::ST_RUNNABLE;
            wd.vrt = (vtmp[32] != vtmp[31]) ? 32'h80000000 : vtmp[31:0];
            sub_nxt = 2'd0; cnt_nxt = cnt_r + 1'b1;
          end
        endcase
      end
      wfts_pkg::P_FIN: ;
      wfts_pkg::P_DONE: ;
      default: ;
    endcase
  end

  // Output beat.
  always_comb begin
    ov_nxt = ph_r == wfts_pkg::P_FIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= wfts_pkg::P_CLEAR; cnt_r <= '0; npid_r <= 16'd1;
      ov_r <= 1'b0; sub_r <= '0;
    end else begin
      ph_r <= ph_nxt; cnt_r <= cnt_nxt; npid_r <= npid_nxt;
      ov_r <= ov_nxt;
      if (ph_r == wfts_pkg::P_EXEC && sub_r == 2'd2 && f_r == wfts_pkg::F_PICK)
        sub_r <= 2'd0;
      else if (ph_r == wfts_pkg::P_DIV && sub_r != 2'd3 && !ddone && sub_r != 2'd0)
        sub_r <= sub_r + 2'd1;
      else if (ph_r == wfts_pkg::P_DIV && sub_r == 2'd0 && !ddone && !div_started_r)
        sub_r <= 2'd1;
      else sub_r <= sub_nxt;
    end
    if (acc) begin
      f_r <= in_func; pidq_r <= in_process_id; sl_r <= in_slot_index;
      nice_r <= in_nice_value; ch_r <= in_wait_channel; vin_r <= in_vruntime_value;
    end
    fu_v_r <= fu_v_nxt; fu_r <= fu_nxt; pm_v_r <= pm_v_nxt; pm_r <= pm_nxt;
    any_r <= any_nxt; mi_r <= mi_nxt; minv_r <= minv_nxt; tot_r <= tot_nxt;
    st_r <= st_nxt; os_r <= os_nxt; on_r <= on_nxt; op_r <= op_nxt; ot_r <= ot_nxt;
    if (ph_r == wfts_pkg::P_EXEC && sub_r == 2'd2) wt_r <= rd_r.weight;
  end

  // Marks that the pick division has been launched.
  always_ff @(posedge clk) begin
    if (!rst_n) div_started_r <= 1'b0;
    else if (ph_r != wfts_pkg::P_DIV) div_started_r <= 1'b0;
    else if (dreq.go) div_started_r <= 1'b1;
  end

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_chosen_slot = os_r;
  assign out_chosen_pid = op_r;
  assign out_nice_out = on_r;
  assign out_time_slice = ot_r;
endmodule
